>>> hw/rtl/yct_pkg.sv
// Package with shared constants, types and helper functions of the YUY2 color tweak core.
`timescale 1ns / 1ps

package yct_pkg;

  localparam int unsigned NumStages = 4;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 14;

  localparam int unsigned GainWidth   = 13;
  localparam int unsigned BrightWidth = 10;
  localparam int unsigned TrigWidth   = 14;

  localparam int unsigned GainFrac = 9;
  localparam int unsigned TrigFrac = 12;

  localparam logic signed [8:0] LumaBase   = 9'sd16;
  localparam logic signed [8:0] ChromaBase = 9'sd128;
  localparam logic [7:0]        ByteMax    = 8'd255;

  localparam logic [GainWidth-1:0]   ContrastReset   = 13'd512;
  localparam logic [BrightWidth-1:0] BrightReset     = 10'd16;
  localparam logic [TrigWidth-1:0]   CosineReset     = 14'd4096;
  localparam logic [TrigWidth-1:0]   SineReset       = 14'd0;
  localparam logic [GainWidth-1:0]   SaturationReset = 13'd512;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CONTRAST_GAIN     = 3'd0,
    REG_BRIGHTNESS_OFFSET = 3'd1,
    REG_HUE_COSINE        = 3'd2,
    REG_HUE_SINE          = 3'd3,
    REG_SATURATION_GAIN   = 3'd4
  } yct_reg_e;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } yct_stage_ctrl_t;

  function automatic logic [7:0] clamp_byte(input logic signed [17:0] x);
    logic [7:0] r;
    if (x < 18'sd0) begin
      r = 8'd0;
    end else if (x > 18'sd255) begin
      r = ByteMax;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/yct_if.sv
// Stream interfaces for the macropixel input and output channels.
`timescale 1ns / 1ps

interface yct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_u;
  logic [7:0] luma_second;
  logic [7:0] chroma_v;

  modport source (output valid, output luma_first, output chroma_u,
                  output luma_second, output chroma_v, input ready);
  modport sink   (input valid, input luma_first, input chroma_u,
                  input luma_second, input chroma_v, output ready);
endinterface

interface yct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first_out;
  logic [7:0] chroma_u_out;
  logic [7:0] luma_second_out;
  logic [7:0] chroma_v_out;

  modport source (output valid, output luma_first_out, output chroma_u_out,
                  output luma_second_out, output chroma_v_out, input ready);
  modport sink   (input valid, input luma_first_out, input chroma_u_out,
                  input luma_second_out, input chroma_v_out, output ready);
endinterface

>>> hw/rtl/yct_ctrl.sv
// Pipeline valid tracking and per-stage advance enables.
`timescale 1ns / 1ps

module yct_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output yct_pkg::yct_stage_ctrl_t ctrl_o
);
  import yct_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.en   = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

>>> hw/rtl/yct_luma.sv
// Luma contrast and brightness datapath for both luma bytes of a macropixel.
`timescale 1ns / 1ps

module yct_luma (
  input  logic                     clk_i,
  input  yct_pkg::yct_stage_ctrl_t ctrl_i,
  input  logic [7:0]               luma_first_i,
  input  logic [7:0]               luma_second_i,
  input  logic [12:0]              contrast_gain_i,
  input  logic signed [9:0]        brightness_offset_i,
  output logic [7:0]               luma_first_o,
  output logic [7:0]               luma_second_o
);
  import yct_pkg::*;

  logic signed [8:0]  diff_first;
  logic signed [8:0]  diff_second;
  logic signed [13:0] gain_s;
  logic signed [22:0] prod_first_q;
  logic signed [22:0] prod_second_q;
  logic signed [22:0] prod_first_d;
  logic signed [22:0] prod_second_d;
  logic signed [17:0] sum_first;
  logic signed [17:0] sum_second;
  logic [7:0]         byte_first_q;
  logic [7:0]         byte_second_q;
  logic [7:0]         dly_first_q;
  logic [7:0]         dly_second_q;
  logic [7:0]         out_first_q;
  logic [7:0]         out_second_q;

  always_comb begin
    gain_s        = $signed({1'b0, contrast_gain_i});
    diff_first    = $signed({1'b0, luma_first_i}) - LumaBase;
    diff_second   = $signed({1'b0, luma_second_i}) - LumaBase;
    prod_first_d  = 23'(diff_first) * 23'(gain_s);
    prod_second_d = 23'(diff_second) * 23'(gain_s);
    sum_first     = 18'($signed(prod_first_q[22:GainFrac])) + 18'(brightness_offset_i);
    sum_second    = 18'($signed(prod_second_q[22:GainFrac])) + 18'(brightness_offset_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      prod_first_q  <= prod_first_d;
      prod_second_q <= prod_second_d;
    end
    if (ctrl_i.en[1]) begin
      byte_first_q  <= clamp_byte(sum_first);
      byte_second_q <= clamp_byte(sum_second);
    end
    if (ctrl_i.en[2]) begin
      dly_first_q  <= byte_first_q;
      dly_second_q <= byte_second_q;
    end
    if (ctrl_i.en[3]) begin
      out_first_q  <= dly_first_q;
      out_second_q <= dly_second_q;
    end
  end

  assign luma_first_o  = out_first_q;
  assign luma_second_o = out_second_q;

endmodule

>>> hw/rtl/yct_chroma.sv
// Chroma hue rotation and saturation datapath.
`timescale 1ns / 1ps

module yct_chroma (
  input  logic                     clk_i,
  input  yct_pkg::yct_stage_ctrl_t ctrl_i,
  input  logic [7:0]               chroma_u_i,
  input  logic [7:0]               chroma_v_i,
  input  logic signed [13:0]       hue_cosine_i,
  input  logic signed [13:0]       hue_sine_i,
  input  logic [12:0]              saturation_gain_i,
  output logic [7:0]               chroma_u_o,
  output logic [7:0]               chroma_v_o
);
  import yct_pkg::*;

  logic signed [8:0]  u_c;
  logic signed [8:0]  v_c;
  logic signed [22:0] uc_q, vs_q, vc_q, us_q;
  logic signed [22:0] uc_d, vs_d, vc_d, us_d;
  logic signed [23:0] ur_sum;
  logic signed [23:0] vr_sum;
  logic signed [11:0] ur_q;
  logic signed [11:0] vr_q;
  logic signed [13:0] sat_s;
  logic signed [25:0] us_prod_d;
  logic signed [25:0] vs_prod_d;
  logic signed [25:0] us_prod_q;
  logic signed [25:0] vs_prod_q;
  logic signed [17:0] uo;
  logic signed [17:0] vo;
  logic [7:0]         out_u_q;
  logic [7:0]         out_v_q;

  always_comb begin
    u_c       = $signed({1'b0, chroma_u_i}) - ChromaBase;
    v_c       = $signed({1'b0, chroma_v_i}) - ChromaBase;
    uc_d      = 23'(u_c) * 23'(hue_cosine_i);
    vs_d      = 23'(v_c) * 23'(hue_sine_i);
    vc_d      = 23'(v_c) * 23'(hue_cosine_i);
    us_d      = 23'(u_c) * 23'(hue_sine_i);
    ur_sum    = 24'(uc_q) + 24'(vs_q);
    vr_sum    = 24'(vc_q) - 24'(us_q);
    sat_s     = $signed({1'b0, saturation_gain_i});
    us_prod_d = 26'(ur_q) * 26'(sat_s);
    vs_prod_d = 26'(vr_q) * 26'(sat_s);
    uo        = 18'($signed(us_prod_q[25:GainFrac])) + 18'(ChromaBase);
    vo        = 18'($signed(vs_prod_q[25:GainFrac])) + 18'(ChromaBase);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      uc_q <= uc_d;
      vs_q <= vs_d;
      vc_q <= vc_d;
      us_q <= us_d;
    end
    if (ctrl_i.en[1]) begin
      ur_q <= $signed(ur_sum[23:TrigFrac]);
      vr_q <= $signed(vr_sum[23:TrigFrac]);
    end
    if (ctrl_i.en[2]) begin
      us_prod_q <= us_prod_d;
      vs_prod_q <= vs_prod_d;
    end
    if (ctrl_i.en[3]) begin
      out_u_q <= clamp_byte(uo);
      out_v_q <= clamp_byte(vo);
    end
  end

  assign chroma_u_o = out_u_q;
  assign chroma_v_o = out_v_q;

endmodule

>>> hw/rtl/yuy2_color_tweak_core.sv
// Top level of the YUY2 color tweak core: registers, pipeline control and datapaths.
//
//   Channel  Direction  Handshake      Payload
//   pix_i    in         valid/ready    luma_first, chroma_u, luma_second, chroma_v
//   pix_o    out        valid/ready    the four adjusted bytes
//   cfg      in         cfg_we_i       cfg_idx_i selects the register, cfg_data_i
//
// Each macropixel passes through a four-stage pipeline; one transfer can enter in
// every cycle unless a stall reaches the first stage. The last stage is the output
// register. A stall holds only the stages that are full; empty stages keep filling.
// Reset clears the valid bits and returns the registers to unity settings.
`timescale 1ns / 1ps

module yuy2_color_tweak_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  yct_in_if.sink                             pix_i,
  yct_out_if.source                          pix_o,
  input  logic                               cfg_we_i,
  input  logic [yct_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [yct_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import yct_pkg::*;

  logic [GainWidth-1:0]   contrast_q;
  logic [BrightWidth-1:0] bright_q;
  logic [TrigWidth-1:0]   cosine_q;
  logic [TrigWidth-1:0]   sine_q;
  logic [GainWidth-1:0]   saturation_q;

  yct_stage_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q   <= ContrastReset;
      bright_q     <= BrightReset;
      cosine_q     <= CosineReset;
      sine_q       <= SineReset;
      saturation_q <= SaturationReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CONTRAST_GAIN:     contrast_q   <= cfg_data_i[GainWidth-1:0];
        REG_BRIGHTNESS_OFFSET: bright_q     <= cfg_data_i[BrightWidth-1:0];
        REG_HUE_COSINE:        cosine_q     <= cfg_data_i[TrigWidth-1:0];
        REG_HUE_SINE:          sine_q       <= cfg_data_i[TrigWidth-1:0];
        REG_SATURATION_GAIN:   saturation_q <= cfg_data_i[GainWidth-1:0];
        default: ;
      endcase
    end
  end

  yct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .ctrl_o      (ctrl)
  );

  yct_luma u_luma (
    .clk_i               (clk_i),
    .ctrl_i              (ctrl),
    .luma_first_i        (pix_i.luma_first),
    .luma_second_i       (pix_i.luma_second),
    .contrast_gain_i     (contrast_q),
    .brightness_offset_i ($signed(bright_q)),
    .luma_first_o        (pix_o.luma_first_out),
    .luma_second_o       (pix_o.luma_second_out)
  );

  yct_chroma u_chroma (
    .clk_i             (clk_i),
    .ctrl_i            (ctrl),
    .chroma_u_i        (pix_i.chroma_u),
    .chroma_v_i        (pix_i.chroma_v),
    .hue_cosine_i      ($signed(cosine_q)),
    .hue_sine_i        ($signed(sine_q)),
    .saturation_gain_i (saturation_q),
    .chroma_u_o        (pix_o.chroma_u_out),
    .chroma_v_o        (pix_o.chroma_v_out)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the YUY2 color tweak core with random flow control.
`timescale 1ns / 1ps

module tb;
  import yct_pkg::*;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_u;
    logic [7:0] luma_second;
    logic [7:0] chroma_v;
  } macropixel_t;

  localparam int NumPhases     = 13;
  localparam int ItemsPerPhase = 115;
  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 5000;
  localparam int ReportLimit   = 10;

  localparam logic [CfgIdxWidth-1:0] RegSpareLow  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegSpareHigh = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_we;
  logic [CfgIdxWidth-1:0]  cfg_idx;
  logic [CfgDataWidth-1:0] cfg_data;

  yct_in_if  pix_in ();
  yct_out_if pix_out ();

  yuy2_color_tweak_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_in),
    .pix_o      (pix_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the register file as the core should hold it.
  logic        [GainWidth-1:0]   contrast_gain_q   = ContrastReset;
  logic signed [BrightWidth-1:0] bright_offset_q   = BrightReset;
  logic signed [TrigWidth-1:0]   hue_cos_q         = CosineReset;
  logic signed [TrigWidth-1:0]   hue_sin_q         = SineReset;
  logic        [GainWidth-1:0]   saturation_gain_q = SaturationReset;

  macropixel_t pending_pix[$];
  macropixel_t expected_pix[$];

  int err_count     = 0;
  int idle_cycles   = 0;
  int tx_gap_max    = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int rx_stall_pct  = 0;
  int hold_request  = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  logic in_fire     = 1'b0;
  logic out_fire    = 1'b0;

  function automatic logic [7:0] sat_byte(longint x);
    if (x < 0) return 8'd0;
    if (x > longint'(ByteMax)) return ByteMax;
    return x[7:0];
  endfunction

  function automatic logic [7:0] tweak_luma(logic [7:0] y);
    longint scaled;
    scaled = ((longint'(y) - longint'(LumaBase)) * longint'(contrast_gain_q)) >>> GainFrac;
    return sat_byte(scaled + longint'(bright_offset_q));
  endfunction

  function automatic macropixel_t color_adjust(macropixel_t px);
    macropixel_t res;
    longint u, v, ur, vr;
    u  = longint'(px.chroma_u) - longint'(ChromaBase);
    v  = longint'(px.chroma_v) - longint'(ChromaBase);
    ur = (u * longint'(hue_cos_q) + v * longint'(hue_sin_q)) >>> TrigFrac;
    vr = (v * longint'(hue_cos_q) - u * longint'(hue_sin_q)) >>> TrigFrac;
    res.luma_first  = tweak_luma(px.luma_first);
    res.luma_second = tweak_luma(px.luma_second);
    res.chroma_u = sat_byte(((ur * longint'(saturation_gain_q)) >>> GainFrac)
                            + longint'(ChromaBase));
    res.chroma_v = sat_byte(((vr * longint'(saturation_gain_q)) >>> GainFrac)
                            + longint'(ChromaBase));
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= ReportLimit)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Input transfers are turned into predictions, output transfers are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire  <= pix_in.valid && pix_in.ready;
      out_fire <= pix_out.valid && pix_out.ready;
      if (pix_in.valid && pix_in.ready) begin
        expected_pix.push_back(color_adjust({pix_in.luma_first, pix_in.chroma_u,
                                             pix_in.luma_second, pix_in.chroma_v}));
        if (pending_pix.size() != 0) void'(pending_pix.pop_front());
      end
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pix.size() == 0) begin
          err_count++;
          if (err_count <= ReportLimit)
            $display("unexpected output transfer: %0d %0d %0d %0d",
                     pix_out.luma_first_out, pix_out.chroma_u_out,
                     pix_out.luma_second_out, pix_out.chroma_v_out);
        end else begin
          check_field("luma_first_out", expected_pix[0].luma_first,
                      pix_out.luma_first_out);
          check_field("chroma_u_out", expected_pix[0].chroma_u, pix_out.chroma_u_out);
          check_field("luma_second_out", expected_pix[0].luma_second,
                      pix_out.luma_second_out);
          check_field("chroma_v_out", expected_pix[0].chroma_v, pix_out.chroma_v_out);
          void'(expected_pix.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_pix.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The sender keeps an offer up until its transfer, then works in bursts.
  always @(negedge clk) begin
    if (pix_in.valid && !in_fire) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      pix_in.valid <= 1'b0;
    end else if (pending_pix.size() != 0) begin
      pix_in.valid       <= 1'b1;
      pix_in.luma_first  <= pending_pix[0].luma_first;
      pix_in.chroma_u    <= pending_pix[0].chroma_u;
      pix_in.luma_second <= pending_pix[0].luma_second;
      pix_in.chroma_v    <= pending_pix[0].chroma_v;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
      end
    end else begin
      pix_in.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_request) begin
      hold_served   <= hold_request;
      hold_left     <= HoldCycles;
      pix_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(1, 100) > rx_stall_pct);
    end
  end

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_CONTRAST_GAIN:     contrast_gain_q   = data[GainWidth-1:0];
      REG_BRIGHTNESS_OFFSET: bright_offset_q   = data[BrightWidth-1:0];
      REG_HUE_COSINE:        hue_cos_q         = data[TrigWidth-1:0];
      REG_HUE_SINE:          hue_sin_q         = data[TrigWidth-1:0];
      REG_SATURATION_GAIN:   saturation_gain_q = data[GainWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int contrast, int bright, int cosine, int sine, int sat);
    write_reg(REG_CONTRAST_GAIN, CfgDataWidth'(contrast));
    write_reg(REG_BRIGHTNESS_OFFSET, CfgDataWidth'(bright));
    write_reg(REG_HUE_COSINE, CfgDataWidth'(cosine));
    write_reg(REG_HUE_SINE, CfgDataWidth'(sine));
    write_reg(REG_SATURATION_GAIN, CfgDataWidth'(sat));
  endtask

  task automatic push_pix(logic [7:0] y0, logic [7:0] u, logic [7:0] y1, logic [7:0] v);
    pending_pix.push_back({y0, u, y1, v});
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: return 8'd0;
        1: return 8'd255;
        2: return 8'd16;
        3: return 8'd15;
        4: return 8'd128;
        5: return 8'd127;
        default: return 8'd129;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_drained();
    while (pending_pix.size() != 0 || expected_pix.size() != 0) @(posedge clk);
  endtask

  initial begin
    pix_in.valid       = 1'b0;
    pix_in.luma_first  = '0;
    pix_in.chroma_u    = '0;
    pix_in.luma_second = '0;
    pix_in.chroma_v    = '0;
    pix_out.ready      = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      case (phase)
        0: ;
        1: apply_setting(5120, 271, 4096, 4096, 5120);
        2: apply_setting(0, -239, -4096, -4096, 0);
        3: apply_setting(5120, -239, -4096, 4096, 0);
        4: apply_setting(0, 271, 4096, -4096, 5120);
        // Raw values beyond the documented ranges use the full field width.
        5: apply_setting(16383, 16383, 16383, 16383, 16383);
        6: apply_setting(8191, 512, 8192, 8191, 4096);
        11: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom);
        12: apply_setting(512, 16, 4096, 0, 512);
        default: apply_setting($urandom_range(0, 5120), $urandom_range(0, 510) - 239,
                               $urandom_range(0, 8192) - 4096,
                               $urandom_range(0, 8192) - 4096, $urandom_range(0, 5120));
      endcase
      if (phase != 0)
        write_reg(CfgIdxWidth'($urandom_range(RegSpareLow, RegSpareHigh)),
                  CfgDataWidth'($urandom));

      if (phase % 4 == 1) begin
        tx_gap_max   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_max   = $urandom_range(1, 8);
        rx_stall_pct = $urandom_range(10, 60);
      end

      if (phase == 7) begin
        tx_gap_max = 0;
        @(posedge clk);
        hold_request++;
      end

      if (phase == 0) begin
        push_pix(8'd0, 8'd0, 8'd0, 8'd0);
        push_pix(8'd255, 8'd255, 8'd255, 8'd255);
        push_pix(8'd16, 8'd128, 8'd16, 8'd128);
        push_pix(8'd15, 8'd127, 8'd15, 8'd127);
        push_pix(8'd17, 8'd129, 8'd17, 8'd129);
        push_pix(8'd0, 8'd255, 8'd255, 8'd0);
        push_pix(8'd255, 8'd0, 8'd0, 8'd255);
        push_pix(8'd235, 8'd240, 8'd16, 8'd16);
        push_pix(8'd16, 8'd16, 8'd235, 8'd240);
        push_pix(8'd128, 8'd0, 8'd128, 8'd255);
        push_pix(8'd255, 8'd128, 8'd0, 8'd128);
        push_pix(8'd0, 8'd128, 8'd255, 8'd128);
      end
      for (int n = 0; n < ItemsPerPhase; n++)
        push_pix(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end

    wait_drained();
    repeat (NumStages * 4) @(posedge clk);
    err_count += expected_pix.size();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> yuy2_color_tweak_core.f
hw/rtl/yct_pkg.sv
hw/rtl/yct_if.sv
hw/rtl/yct_ctrl.sv
hw/rtl/yct_luma.sv
hw/rtl/yct_chroma.sv
hw/rtl/yuy2_color_tweak_core.sv
sim/tb.sv
